@@ design/case_insensitive_string_interner_top_defines.svh @@
// Assertion macros for the case-insensitive string interner.
// Included by the top level; no other dependencies.
`ifndef CASE_INSENSITIVE_STRING_INTERNER_TOP_DEFINES_SVH
`define CASE_INSENSITIVE_STRING_INTERNER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CISI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CISI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CISI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define CISI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ design/cisi_pkg.sv @@
// Shared types, constants and helpers for the case-insensitive string interner.
// Used by cisi_ctrl, cisi_dpath and the top level; depends on nothing.
package cisi_pkg;

  localparam int unsigned TABLE_SLOTS = 512;    // power of two
  localparam int unsigned STORE_BYTES = 65536;
  localparam int unsigned MAX_LENGTH  = 255;

  localparam int unsigned SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W   = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned SADDR_W = $clog2(STORE_BYTES);
  localparam int unsigned USED_W  = $clog2(STORE_BYTES + 1);
  localparam int unsigned PEND_W  = 9;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned PROBE_W = 10;
  localparam int unsigned LIMIT_W = 10;

  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  localparam logic [2:0] STATUS_FOUND      = 3'd0;
  localparam logic [2:0] STATUS_INSERTED   = 3'd1;
  localparam logic [2:0] STATUS_TOO_LONG   = 3'd2;
  localparam logic [2:0] STATUS_TABLE_FULL = 3'd3;
  localparam logic [2:0] STATUS_STORE_FULL = 3'd4;

  localparam logic REG_ENTRY_LIMIT = 1'b0;
  localparam logic [LIMIT_W-1:0] ENTRY_LIMIT_RESET = 10'd358;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_RUN, ST_PROBE_RD, ST_PROBE_CHK, ST_LEN_CHK, ST_CMP_RD, ST_CMP_CHK,
    ST_INS_CHK, ST_INS_RD, ST_INS_WR, ST_INS_END, ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    RES_EMPTY, RES_TOO_LONG, RES_HIT, RES_TABLE_FULL, RES_STORE_FULL, RES_INSERTED
  } res_e;

  typedef struct packed {
    logic clr_step;
    logic take;
    logic probe_start;
    logic probe_inc;
    logic rd_len;
    logic advance;
    logic miss_empty;
    logic miss_full;
    logic idx_clr;
    logic idx_inc;
    logic ins_hdr;
    logic ins_byte;
    logic ins_end;
    logic res_set;
    res_e res_code;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic slot_empty;
    logic hash_eq;
    logic len_eq;
    logic byte_eq;
    logic idx_last;
    logic visit_last;
    logic table_full;
    logic store_full;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    fold_case = (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
  endfunction

endpackage

@@ design/cisi_ctrl.sv @@
// Controller state machine of the string interner.
// Depends on cisi_pkg; drives cisi_dpath through cmd_t and reads sts_t.
module cisi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  input  logic           s_tlast_i,
  input  logic           s_tuser_i,
  input  logic           too_long_i,
  input  cisi_pkg::sts_t sts_i,
  output logic           s_tready_o,
  output cisi_pkg::cmd_t cmd_o
);

  cisi_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cisi_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cisi_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) state_d = cisi_pkg::ST_RUN;
      end
      cisi_pkg::ST_RUN: begin
        if (s_tvalid_i) begin
          if (s_tuser_i) state_d = cisi_pkg::ST_DONE;
          else if (s_tlast_i) state_d = too_long_i ? cisi_pkg::ST_DONE : cisi_pkg::ST_PROBE_RD;
        end
      end
      cisi_pkg::ST_PROBE_RD: state_d = cisi_pkg::ST_PROBE_CHK;
      cisi_pkg::ST_PROBE_CHK: begin
        if (sts_i.slot_empty) state_d = cisi_pkg::ST_INS_CHK;
        else if (sts_i.hash_eq) state_d = cisi_pkg::ST_LEN_CHK;
        else state_d = sts_i.visit_last ? cisi_pkg::ST_INS_CHK : cisi_pkg::ST_PROBE_RD;
      end
      cisi_pkg::ST_LEN_CHK: begin
        if (sts_i.len_eq) state_d = cisi_pkg::ST_CMP_RD;
        else state_d = sts_i.visit_last ? cisi_pkg::ST_INS_CHK : cisi_pkg::ST_PROBE_RD;
      end
      cisi_pkg::ST_CMP_RD: state_d = cisi_pkg::ST_CMP_CHK;
      cisi_pkg::ST_CMP_CHK: begin
        if (!sts_i.byte_eq) begin
          state_d = sts_i.visit_last ? cisi_pkg::ST_INS_CHK : cisi_pkg::ST_PROBE_RD;
        end else begin
          state_d = sts_i.idx_last ? cisi_pkg::ST_DONE : cisi_pkg::ST_CMP_RD;
        end
      end
      cisi_pkg::ST_INS_CHK: begin
        if (sts_i.table_full || sts_i.store_full) state_d = cisi_pkg::ST_DONE;
        else state_d = cisi_pkg::ST_INS_RD;
      end
      cisi_pkg::ST_INS_RD: state_d = cisi_pkg::ST_INS_WR;
      cisi_pkg::ST_INS_WR: state_d = sts_i.idx_last ? cisi_pkg::ST_INS_END : cisi_pkg::ST_INS_RD;
      cisi_pkg::ST_INS_END: state_d = cisi_pkg::ST_DONE;
      cisi_pkg::ST_DONE: begin
        if (sts_i.out_free) state_d = cisi_pkg::ST_RUN;
      end
      default: state_d = cisi_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res_code = cisi_pkg::RES_EMPTY;
    s_tready_o = 1'b0;
    unique case (state_q)
      cisi_pkg::ST_CLEAR: cmd_o.clr_step = 1'b1;
      cisi_pkg::ST_RUN: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.take = 1'b1;
          if (s_tuser_i) begin
            cmd_o.res_set = 1'b1;
            cmd_o.res_code = cisi_pkg::RES_EMPTY;
          end else if (s_tlast_i) begin
            if (too_long_i) begin
              cmd_o.res_set = 1'b1;
              cmd_o.res_code = cisi_pkg::RES_TOO_LONG;
            end else begin
              cmd_o.probe_start = 1'b1;
            end
          end
        end
      end
      cisi_pkg::ST_PROBE_RD: ;
      cisi_pkg::ST_PROBE_CHK: begin
        if (sts_i.slot_empty) begin
          cmd_o.miss_empty = 1'b1;
        end else begin
          cmd_o.probe_inc = 1'b1;
          if (sts_i.hash_eq) begin
            cmd_o.rd_len = 1'b1;
          end else begin
            cmd_o.advance = 1'b1;
            cmd_o.miss_full = sts_i.visit_last;
          end
        end
      end
      cisi_pkg::ST_LEN_CHK: begin
        if (sts_i.len_eq) begin
          cmd_o.idx_clr = 1'b1;
        end else begin
          cmd_o.advance = 1'b1;
          cmd_o.miss_full = sts_i.visit_last;
        end
      end
      cisi_pkg::ST_CMP_RD: ;
      cisi_pkg::ST_CMP_CHK: begin
        if (!sts_i.byte_eq) begin
          cmd_o.advance = 1'b1;
          cmd_o.miss_full = sts_i.visit_last;
        end else if (sts_i.idx_last) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_code = cisi_pkg::RES_HIT;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      cisi_pkg::ST_INS_CHK: begin
        if (sts_i.table_full) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_code = cisi_pkg::RES_TABLE_FULL;
        end else if (sts_i.store_full) begin
          cmd_o.res_set = 1'b1;
          cmd_o.res_code = cisi_pkg::RES_STORE_FULL;
        end else begin
          cmd_o.ins_hdr = 1'b1;
          cmd_o.idx_clr = 1'b1;
        end
      end
      cisi_pkg::ST_INS_RD: ;
      cisi_pkg::ST_INS_WR: begin
        cmd_o.ins_byte = 1'b1;
        cmd_o.idx_inc = !sts_i.idx_last;
      end
      cisi_pkg::ST_INS_END: begin
        cmd_o.ins_end = 1'b1;
        cmd_o.res_set = 1'b1;
        cmd_o.res_code = cisi_pkg::RES_INSERTED;
      end
      cisi_pkg::ST_DONE: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ design/cisi_dpath.sv @@
// Datapath of the string interner: hash, staging buffer, slot table, byte store
// and the output register. Depends on cisi_pkg; commanded by cisi_ctrl.
module cisi_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cisi_pkg::cmd_t                  cmd_i,
  input  logic [7:0]                      char_byte_i,
  input  logic                            empty_i,
  input  logic                            last_i,
  input  logic [cisi_pkg::LIMIT_W-1:0]    entry_limit_i,
  input  logic                            m_tready_i,
  output logic                            too_long_o,
  output cisi_pkg::sts_t                  sts_o,
  output logic                            m_tvalid_o,
  output logic [39:0]                     m_tdata_o
);

  localparam int unsigned SW = cisi_pkg::SLOT_W;
  localparam int unsigned AW = cisi_pkg::SADDR_W;
  localparam int unsigned UW = cisi_pkg::USED_W;
  localparam int unsigned PW = cisi_pkg::PEND_W;
  localparam int unsigned CW = cisi_pkg::CNT_W;

  logic [31:0] slot_hash_mem [cisi_pkg::TABLE_SLOTS];
  logic [15:0] slot_off_mem  [cisi_pkg::TABLE_SLOTS];
  logic [7:0]  store_mem     [cisi_pkg::STORE_BYTES];
  logic [7:0]  stg_mem       [cisi_pkg::MAX_LENGTH];

  logic [31:0] hash_q, str_hash_q, hash_nxt;
  logic [PW-1:0] pend_q, pend_nxt;
  logic [7:0] str_len_q, idx_q;
  logic [SW-1:0] slot_q, clr_q;
  logic [CW-1:0] visit_q, entry_q;
  logic [cisi_pkg::PROBE_W-1:0] probe_q;
  logic [15:0] cand_off_q;
  logic [UW-1:0] used_q;
  logic ended_empty_q;
  logic [31:0] slot_hash_rd;
  logic [15:0] slot_off_rd;
  logic [7:0] store_rd, stg_rd;
  logic [AW-1:0] store_rd_addr, store_wr_addr;
  logic [7:0] store_wr_data;
  logic store_we;
  logic [15:0] new_off;
  logic [15:0] res_id_q;
  logic [2:0] res_st_q;
  logic [cisi_pkg::PROBE_W-1:0] res_probe_q;
  logic [7:0] res_len_q;
  logic m_valid_q;
  logic [39:0] m_data_q;

  // Byte absorb: fold, FNV-1a step and saturating length.
  assign hash_nxt = (hash_q ^ {24'd0, cisi_pkg::fold_case(char_byte_i)}) * cisi_pkg::HASH_PRIME;
  assign pend_nxt = (pend_q < PW'(cisi_pkg::MAX_LENGTH)) ? pend_q + 1'b1
                                                          : PW'(cisi_pkg::MAX_LENGTH + 1);
  assign too_long_o = pend_nxt > PW'(cisi_pkg::MAX_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= cisi_pkg::HASH_BASIS;
      pend_q <= '0;
    end else if (cmd_i.take) begin
      if (empty_i || last_i) begin
        hash_q <= cisi_pkg::HASH_BASIS;
        pend_q <= '0;
      end else begin
        pend_q <= pend_nxt;
        if (pend_q < PW'(cisi_pkg::MAX_LENGTH)) hash_q <= hash_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && !empty_i && pend_q < PW'(cisi_pkg::MAX_LENGTH)) begin
      stg_mem[pend_q[7:0]] <= char_byte_i;
    end
    stg_rd <= stg_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_start) begin
      str_hash_q <= (pend_q < PW'(cisi_pkg::MAX_LENGTH)) ? hash_nxt : hash_q;
      str_len_q  <= pend_nxt[7:0];
    end
    if (cmd_i.probe_inc) cand_off_q <= slot_off_rd;
    if (cmd_i.idx_clr) idx_q <= '0;
    else if (cmd_i.idx_inc) idx_q <= idx_q + 1'b1;
  end

  // Slot table: cleared after reset, one read and one write per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      slot_hash_mem[clr_q] <= '0;
      slot_off_mem[clr_q]  <= '0;
    end else if (cmd_i.ins_end) begin
      slot_hash_mem[slot_q] <= str_hash_q;
      slot_off_mem[slot_q]  <= new_off;
    end
    slot_hash_rd <= slot_hash_mem[slot_q];
    slot_off_rd  <= slot_off_mem[slot_q];
  end

  assign new_off = 16'(used_q + 1'b1);

  always_comb begin
    store_we = 1'b0;
    store_wr_addr = AW'(used_q);
    store_wr_data = str_len_q;
    if (cmd_i.ins_hdr) begin
      store_we = 1'b1;
    end else if (cmd_i.ins_byte) begin
      store_we = 1'b1;
      store_wr_addr = AW'(used_q + 1'b1 + UW'(idx_q));
      store_wr_data = stg_rd;
    end else if (cmd_i.ins_end) begin
      store_we = 1'b1;
      store_wr_addr = AW'(used_q + 1'b1 + UW'(str_len_q));
      store_wr_data = 8'd0;
    end
  end

  assign store_rd_addr = cmd_i.rd_len ? AW'(slot_off_rd - 1'b1) : AW'(cand_off_q + 16'(idx_q));

  always_ff @(posedge clk_i) begin
    if (store_we) store_mem[store_wr_addr] <= store_wr_data;
    store_rd <= store_mem[store_rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      slot_q <= '0;
      visit_q <= '0;
      probe_q <= '0;
      ended_empty_q <= 1'b0;
      used_q <= UW'(1);
      entry_q <= '0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.probe_start) begin
        slot_q <= ((pend_q < PW'(cisi_pkg::MAX_LENGTH)) ? hash_nxt[SW-1:0] : hash_q[SW-1:0]);
        visit_q <= '0;
        probe_q <= '0;
      end
      if (cmd_i.probe_inc) probe_q <= probe_q + 1'b1;
      if (cmd_i.advance) begin
        slot_q <= slot_q + 1'b1;
        visit_q <= visit_q + 1'b1;
      end
      if (cmd_i.miss_empty) ended_empty_q <= 1'b1;
      if (cmd_i.miss_full) ended_empty_q <= 1'b0;
      if (cmd_i.ins_end) begin
        used_q <= used_q + UW'(str_len_q) + UW'(2);
        entry_q <= entry_q + 1'b1;
      end
    end
  end

  // Result fields, staged until the output register is free.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_id_q <= '0;
      res_probe_q <= probe_q;
      res_len_q <= '0;
      unique case (cmd_i.res_code)
        cisi_pkg::RES_EMPTY: begin
          res_st_q <= cisi_pkg::STATUS_FOUND;
          res_probe_q <= '0;
        end
        cisi_pkg::RES_TOO_LONG: begin
          res_st_q <= cisi_pkg::STATUS_TOO_LONG;
          res_probe_q <= '0;
        end
        cisi_pkg::RES_HIT: begin
          res_st_q <= cisi_pkg::STATUS_FOUND;
          res_id_q <= cand_off_q;
          res_len_q <= str_len_q;
        end
        cisi_pkg::RES_TABLE_FULL: res_st_q <= cisi_pkg::STATUS_TABLE_FULL;
        cisi_pkg::RES_STORE_FULL: res_st_q <= cisi_pkg::STATUS_STORE_FULL;
        cisi_pkg::RES_INSERTED: begin
          res_st_q <= cisi_pkg::STATUS_INSERTED;
          res_id_q <= new_off;
          res_len_q <= str_len_q;
        end
        default: res_st_q <= cisi_pkg::STATUS_FOUND;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) m_data_q <= {3'd0, res_len_q, res_probe_q, res_st_q, res_id_q};
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  assign sts_o.clr_last   = clr_q == SW'(cisi_pkg::TABLE_SLOTS - 1);
  assign sts_o.slot_empty = slot_off_rd == 16'd0;
  assign sts_o.hash_eq    = slot_hash_rd == str_hash_q;
  assign sts_o.len_eq     = store_rd == str_len_q;
  assign sts_o.byte_eq    = cisi_pkg::fold_case(store_rd) == cisi_pkg::fold_case(stg_rd);
  assign sts_o.idx_last   = ({1'b0, idx_q} + 9'd1) == {1'b0, str_len_q};
  assign sts_o.visit_last = visit_q == CW'(cisi_pkg::TABLE_SLOTS - 1);
  assign sts_o.table_full = ({1'b0, entry_q} + 1'b1 > {1'b0, entry_limit_i})
                         || (entry_q >= CW'(cisi_pkg::TABLE_SLOTS)) || !ended_empty_q;
  assign sts_o.store_full = ({1'b0, used_q} + {{(UW-7){1'b0}}, str_len_q} + (UW+1)'(2)
                             > (UW+1)'(cisi_pkg::STORE_BYTES))
                         || (used_q >= UW'(16'hFFFF));
  assign sts_o.out_free   = !m_valid_q || m_tready_i;

endmodule

@@ design/case_insensitive_string_interner_top.sv @@
// Top level of the case-insensitive string interner: APB register, controller
// and datapath. Depends on cisi_pkg, cisi_ctrl, cisi_dpath and the defines header.
//
//   Channel   Direction  Contents
//   s_*       in         one string byte per item, tlast ends it, tuser = empty
//   m_*       out        one result item per string end
//   APB       in/out     register 0: entry_limit at byte address 0
//
// Items are taken only in the run state; the FNV-1a multiply is done in the cycle
// that takes a byte. A string end reads and checks each probed slot, plus a length
// check where the stored hash matches, reads and checks each compared byte, or reads
// and writes each byte on insert, with setup and result states, on one slot table
// port and one byte store port. After reset all 512 slots are cleared, no item taken.
// A waiting result holds back all further items, bytes too, until output is free.
`include "case_insensitive_string_interner_top_defines.svh"
module case_insensitive_string_interner_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] char_byte
  input  logic        s_tlast_i,   // last_char
  input  logic        s_tuser_i,   // empty_string
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // [15:0] string_id, [18:16] status, [28:19] slots_probed, [36:29] string_length
  output logic [39:0] m_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cisi_pkg::cmd_t cmd;
  cisi_pkg::sts_t sts;
  logic too_long;
  logic [cisi_pkg::LIMIT_W-1:0] entry_limit_q;
  logic out_free;
  logic end_taken;

  // The only register is decoded from the word address bit; byte lanes are ignored.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == cisi_pkg::REG_ENTRY_LIMIT)
                ? {{(32-cisi_pkg::LIMIT_W){1'b0}}, entry_limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_limit_q <= cisi_pkg::ENTRY_LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == cisi_pkg::REG_ENTRY_LIMIT) begin
      entry_limit_q <= pwdata[cisi_pkg::LIMIT_W-1:0];
    end
  end

  cisi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tlast_i  (s_tlast_i),
    .s_tuser_i  (s_tuser_i),
    .too_long_i (too_long),
    .sts_i      (sts),
    .s_tready_o (s_tready_o),
    .cmd_o      (cmd)
  );

  cisi_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .char_byte_i   (s_tdata_i),
    .empty_i       (s_tuser_i),
    .last_i        (s_tlast_i),
    .entry_limit_i (entry_limit_q),
    .m_tready_i    (m_tready_i),
    .too_long_o    (too_long),
    .sts_o         (sts),
    .m_tvalid_o    (m_tvalid_o),
    .m_tdata_o     (m_tdata_o)
  );

  assign out_free  = !m_tvalid_o || m_tready_i;
  assign end_taken = s_tvalid_i && s_tready_o && (s_tlast_i || s_tuser_i);

  // No item is taken while the slot table is being cleared.
  `CISI_ASSERT_SAME(a_no_take_in_clear, clk_i, rst_ni, cmd.clr_step, !s_tready_o, "clear take")
  // A result is loaded only into a free output register.
  `CISI_ASSERT_SAME(a_load_when_free, clk_i, rst_ni, cmd.out_load, out_free, "overwrite")
  // The end of a string always leaves the byte-taking state.
  `CISI_ASSERT_NEXT(a_end_blocks, clk_i, rst_ni, end_taken, !s_tready_o, "end not held")

endmodule
